>>> rtl/cfr_pkg.sv
`timescale 1ns / 1ps
// cfr_pkg: shared constants, types and the fletcher fold for the frame receiver
// used by every module of the checked frame receiver but cfr_ram; depends on nothing

package cfr_pkg;

   localparam int BUFFER_BYTES = 2048;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int POS_W        = ADDR_W + 1;
   localparam int BANKS        = 4;
   localparam int BANK_W       = $clog2(BANKS);
   localparam int ROW_DEPTH    = BUFFER_BYTES / BANKS;
   localparam int ROW_W        = $clog2(ROW_DEPTH);
   localparam int HEADER_SIZE  = 10;
   localparam int CHECK_BYTES  = 2;
   localparam int MAX_LENGTH   = BUFFER_BYTES - HEADER_SIZE - CHECK_BYTES;

   localparam logic [15:0] TYPE_ALLOWED = 16'h83FF;
   localparam logic [7:0]  FLETCHER_MOD = 8'hFF;
   localparam logic [7:0]  SYNC_FIRST   = 8'h44;
   localparam logic [7:0]  SYNC_SECOND  = 8'h46;
   // fletcher sums right after folding the sync pair
   localparam logic [7:0]  SYNC_LOW     = 8'd138;
   localparam logic [7:0]  SYNC_HIGH    = 8'd206;

   typedef enum logic [1:0] {
      CMD_RECEIVE    = 2'd0,
      CMD_READ_BYTE  = 2'd1,
      CMD_READ_WORD  = 2'd2,
      CMD_READ_DWORD = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      PHASE_HUNT   = 3'b001,
      PHASE_HEADER = 3'b010,
      PHASE_DATA   = 3'b100
   } phase_type;

   typedef struct packed {
      logic        frame_done;
      logic        checksum_ok;
      logic [15:0] frame_type;
      logic [31:0] frame_id;
      logic [10:0] frame_length;
      logic [11:0] bytes_left;
      logic        at_end;
   } rsp_fields_type;

   typedef struct packed {
      logic              rd_ok;
      logic [2:0]        count;
      logic [BANK_W-1:0] rp_lo;
      logic              rp_is0;
      logic              rp_is1;
   } read_tag_type;

   typedef struct packed {
      logic                         we;
      logic [BANK_W-1:0]            wbank;
      logic [ROW_W-1:0]             wrow;
      logic [7:0]                   wdata;
      logic                         re;
      logic [BANKS-1:0][ROW_W-1:0]  rrow;
   } mem_req_type;

   function automatic logic [7:0] fletcher_fold(input logic [7:0] sum, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, sum} + {1'b0, b};
      if (s >= {1'b0, FLETCHER_MOD}) begin
         s = s - {1'b0, FLETCHER_MOD};
      end
      return s[7:0];
   endfunction

endpackage

>>> rtl/cfr_ram.sv
`timescale 1ns / 1ps
// cfr_ram: generic simple dual port ram, one write and one registered read per cycle
// no package dependency

module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/cfr_parser.sv
`timescale 1ns / 1ps
// cfr_parser: sync hunt, header capture, fletcher sums and fill/read positions
// drives the byte-lane memory requests; depends on cfr_pkg

module cfr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  cfr_pkg::cmd_type       command,
   input  logic [7:0]             rx_byte,
   output cfr_pkg::mem_req_type   mem_req,
   output cfr_pkg::rsp_fields_type fields,
   output cfr_pkg::read_tag_type  tag
);

   localparam int POS_W  = cfr_pkg::POS_W;
   localparam int BANK_W = cfr_pkg::BANK_W;
   localparam int ROW_W  = cfr_pkg::ROW_W;

   cfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]       prev_ff, prev_in;
   logic [POS_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] read_ff, read_in;
   logic [7:0]       low_ff, low_in;
   logic [7:0]       high_ff, high_in;
   logic [31:0]      id_ff, id_in;
   logic [15:0]      type_ff, type_in;
   logic [15:0]      len_ff, len_in;

   logic [7:0]       low_fold, high_fold;
   logic [POS_W-1:0] fill_inc;
   logic [15:0]      len_chk;
   logic             frame_end;
   logic [2:0]       count;
   logic [POS_W:0]   end_pos;
   logic             rd_ok;
   logic [BANK_W-1:0] offset;
   logic [POS_W:0]   row_pos;

   assign low_fold  = cfr_pkg::fletcher_fold(low_ff, rx_byte);
   assign high_fold = cfr_pkg::fletcher_fold(high_ff, low_fold);
   assign fill_inc  = fill_ff + POS_W'(1);
   assign len_chk   = {rx_byte, len_ff[7:0]};
   assign frame_end = (17'(fill_inc) ==
                       17'(len_ff) + 17'(cfr_pkg::HEADER_SIZE + cfr_pkg::CHECK_BYTES));

   always_comb begin
      unique case (command)
         cfr_pkg::CMD_READ_BYTE: count = 3'd1;
         cfr_pkg::CMD_READ_WORD: count = 3'd2;
         default:                count = 3'd4;
      endcase
   end

   assign end_pos = {1'b0, read_ff} + (POS_W + 1)'(count);
   assign rd_ok   = (end_pos <= {1'b0, fill_ff});

   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      fill_in  = fill_ff;
      read_in  = read_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      id_in    = id_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      fields   = '0;
      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.wbank = fill_ff[BANK_W-1:0];
      mem_req.wrow  = fill_ff[BANK_W +: ROW_W];
      mem_req.wdata = rx_byte;
      tag.rd_ok  = 1'b0;
      tag.count  = count;
      tag.rp_lo  = read_ff[BANK_W-1:0];
      tag.rp_is0 = (read_ff == POS_W'(0));
      tag.rp_is1 = (read_ff == POS_W'(1));

      // each bank reads the row holding its byte of the window starting at read_ff
      for (int j = 0; j < cfr_pkg::BANKS; j++) begin
         offset  = BANK_W'(j) - read_ff[BANK_W-1:0];
         row_pos = {1'b0, read_ff} + (POS_W + 1)'(offset);
         mem_req.rrow[j] = row_pos[BANK_W +: ROW_W];
      end

      if (accept) begin
         if (command == cfr_pkg::CMD_RECEIVE) begin
            unique case (phase_ff)
               cfr_pkg::PHASE_HEADER: begin
                  mem_req.we = 1'b1;
                  fill_in    = fill_inc;
                  low_in     = low_fold;
                  high_in    = high_fold;
                  // shadow copy of header bytes 2..9
                  unique case (fill_ff[3:0])
                     4'd2:    id_in[7:0]    = rx_byte;
                     4'd3:    id_in[15:8]   = rx_byte;
                     4'd4:    id_in[23:16]  = rx_byte;
                     4'd5:    id_in[31:24]  = rx_byte;
                     4'd6:    type_in[7:0]  = rx_byte;
                     4'd7:    type_in[15:8] = rx_byte;
                     4'd8:    len_in[7:0]   = rx_byte;
                     4'd9:    len_in[15:8]  = rx_byte;
                     default: len_in        = len_ff;
                  endcase
                  if (fill_inc == POS_W'(cfr_pkg::HEADER_SIZE)) begin
                     if (len_chk > 16'(cfr_pkg::MAX_LENGTH) ||
                         (type_ff & ~cfr_pkg::TYPE_ALLOWED) != 16'd0) begin
                        phase_in = cfr_pkg::PHASE_HUNT;
                     end else begin
                        phase_in = cfr_pkg::PHASE_DATA;
                     end
                  end
               end
               cfr_pkg::PHASE_DATA: begin
                  mem_req.we = 1'b1;
                  fill_in    = fill_inc;
                  low_in     = low_fold;
                  high_in    = high_fold;
                  if (frame_end) begin
                     phase_in            = cfr_pkg::PHASE_HUNT;
                     fields.frame_done   = 1'b1;
                     fields.frame_type   = type_ff;
                     fields.frame_id     = id_ff;
                     fields.frame_length = len_ff[10:0];
                     if (low_fold == 8'd0 && high_fold == 8'd0) begin
                        fields.checksum_ok = 1'b1;
                        fill_in = fill_inc - POS_W'(cfr_pkg::CHECK_BYTES);
                        read_in = POS_W'(cfr_pkg::HEADER_SIZE);
                     end else begin
                        // bad frame: nothing left to read
                        read_in = fill_inc;
                     end
                  end
               end
               default: begin
                  if (rx_byte == cfr_pkg::SYNC_SECOND && prev_ff == cfr_pkg::SYNC_FIRST) begin
                     fill_in  = POS_W'(2);
                     prev_in  = 8'd0;
                     phase_in = cfr_pkg::PHASE_HEADER;
                     low_in   = cfr_pkg::SYNC_LOW;
                     high_in  = cfr_pkg::SYNC_HIGH;
                  end else begin
                     prev_in = rx_byte;
                  end
               end
            endcase
         end else begin
            if (rd_ok) begin
               mem_req.re = 1'b1;
               tag.rd_ok  = 1'b1;
               read_in    = end_pos[POS_W-1:0];
            end else if (count != 3'd1) begin
               read_in = fill_ff;
            end
         end
      end

      fields.bytes_left = (fill_in > read_in) ? 12'(fill_in - read_in) : 12'd0;
      fields.at_end     = (read_in >= fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfr_pkg::PHASE_HUNT;
         prev_ff  <= 8'd0;
         fill_ff  <= '0;
         read_ff  <= '0;
         low_ff   <= 8'd0;
         high_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         fill_ff  <= fill_in;
         read_ff  <= read_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      type_ff <= type_in;
      len_ff  <= len_in;
   end

endmodule

>>> rtl/cfr_read_align.sv
`timescale 1ns / 1ps
// cfr_read_align: rotates the four byte-lane outputs into a little-endian read value
// depends on cfr_pkg

module cfr_read_align (
   input  cfr_pkg::read_tag_type              tag,
   input  logic [cfr_pkg::BANKS-1:0][7:0]     bank_data,
   output logic [31:0]                        read_value
);

   localparam int BANK_W = cfr_pkg::BANK_W;

   logic [BANK_W-1:0] lane;
   logic [7:0]        byte_val;

   always_comb begin
      read_value = 32'd0;
      for (int k = 0; k < cfr_pkg::BANKS; k++) begin
         lane     = tag.rp_lo + BANK_W'(k);
         byte_val = bank_data[lane];
         // the two sync bytes at the start of the buffer are never written
         if (k == 0 && tag.rp_is0) begin
            byte_val = cfr_pkg::SYNC_FIRST;
         end
         if ((k == 1 && tag.rp_is0) || (k == 0 && tag.rp_is1)) begin
            byte_val = cfr_pkg::SYNC_SECOND;
         end
         if (tag.rd_ok && 3'(k) < tag.count) begin
            read_value[8*k +: 8] = byte_val;
         end
      end
   end

endmodule

>>> rtl/checked_frame_receiver.sv
`timescale 1ns / 1ps
// checked_frame_receiver: top level, parser, four byte-lane buffer rams and response stage
// depends on cfr_pkg, cfr_parser, cfr_ram and cfr_read_align

// Byte-serial frame receiver with Fletcher-16 checking. It takes one item per clock,
// receive and read commands alike, and returns its result in the cycle after acceptance
// through a registered response stage; a stalled response holds off new items only while
// it waits. The frame buffer is split into four byte-lane memories of 512 bytes, so any
// unaligned word or dword read fetches all its bytes in parallel. The buffer needs no
// clearing after reset; bytes read before they were ever received are unspecified. All
// positions and sums sit in flip-flops and update as each item enters.

module checked_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_done,
   output logic        rsp_checksum_ok,
   output logic [15:0] rsp_frame_type,
   output logic [31:0] rsp_frame_id,
   output logic [10:0] rsp_frame_length,
   output logic [31:0] rsp_read_value,
   output logic [11:0] rsp_bytes_left,
   output logic        rsp_at_end
);

   logic                             accept;
   cfr_pkg::mem_req_type             mem_req;
   cfr_pkg::rsp_fields_type          fields;
   cfr_pkg::read_tag_type            tag;
   logic [cfr_pkg::BANKS-1:0][7:0]   bank_data;

   logic                             rsp_valid_ff, rsp_valid_in;
   cfr_pkg::rsp_fields_type          fields_ff;
   cfr_pkg::read_tag_type            tag_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   cfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .command (cfr_pkg::cmd_type'(req_command)),
      .rx_byte (req_rx_byte),
      .mem_req (mem_req),
      .fields  (fields),
      .tag     (tag)
   );

   for (genvar j = 0; j < cfr_pkg::BANKS; j++) begin : g_bank
      cfr_ram #(
         .WIDTH (8),
         .DEPTH (cfr_pkg::ROW_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (mem_req.we && mem_req.wbank == cfr_pkg::BANK_W'(j)),
         .waddr (mem_req.wrow),
         .wdata (mem_req.wdata),
         .re    (mem_req.re),
         .raddr (mem_req.rrow[j]),
         .rdata (bank_data[j])
      );
   end

   cfr_read_align u_align (
      .tag        (tag_ff),
      .bank_data  (bank_data),
      .read_value (rsp_read_value)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ram read data stays put while the item waits, since no read is issued then
   always_ff @(posedge clock) begin
      if (accept) begin
         fields_ff <= fields;
         tag_ff    <= tag;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_done   = fields_ff.frame_done;
   assign rsp_checksum_ok  = fields_ff.checksum_ok;
   assign rsp_frame_type   = fields_ff.frame_type;
   assign rsp_frame_id     = fields_ff.frame_id;
   assign rsp_frame_length = fields_ff.frame_length;
   assign rsp_bytes_left   = fields_ff.bytes_left;
   assign rsp_at_end       = fields_ff.at_end;

endmodule

>>> tb/checked_frame_receiver_tb.sv
`timescale 1ns / 1ps
// checked_frame_receiver_tb: self-checking bench for the fletcher-16 frame receiver
// streams framed bytes and payload reads, predicts each response; needs cfr_pkg and the rtl

module checked_frame_receiver_tb;
   import cfr_pkg::*;

   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [7:0] STALL_PATTERN = 8'b1101_1001;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN,
      READY_SPARSE
   } ready_mode_t;

   typedef struct {
      cmd_type    cmd;
      logic [7:0] data;
      bit         drain_first;
   } rx_item_t;

   typedef struct packed {
      logic        done;
      logic        ok;
      logic [15:0] ftype;
      logic [31:0] fid;
      logic [10:0] flen;
      logic [31:0] rval;
      logic [11:0] left;
      logic        at_end;
   } rx_result_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cmd_type     req_command = CMD_RECEIVE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_frame_done;
   logic        rsp_checksum_ok;
   logic [15:0] rsp_frame_type;
   logic [31:0] rsp_frame_id;
   logic [10:0] rsp_frame_length;
   logic [31:0] rsp_read_value;
   logic [11:0] rsp_bytes_left;
   logic        rsp_at_end;

   // shadow of the receiver state
   phase_type   rx_phase = PHASE_HUNT;
   logic [7:0]  last_rx = 8'h00;
   logic [7:0]  shadow_store [BUFFER_BYTES];
   int unsigned fill_pos = 0;
   int unsigned read_pos = 0;
   int unsigned sum_lo = 0;
   int unsigned sum_hi = 0;

   rx_item_t    rx_items[$];
   rx_result_t  awaited_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          stim_count = 0;
   bit          drain_next = 1'b0;
   logic        item_taken = 1'b0;
   int          gap_left = 0;
   int          burst_left = 0;
   ready_mode_t ready_mode = READY_ALWAYS;
   int          mode_left = 0;
   logic [2:0]  pattern_idx = 3'd0;

   checked_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_read_value   (rsp_read_value),
      .rsp_bytes_left   (rsp_bytes_left),
      .rsp_at_end       (rsp_at_end)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic logic [31:0] gather_le(int unsigned idx, int unsigned n);
      logic [31:0] v;
      v = '0;
      for (int k = 0; k < n; k++) begin
         if (idx + k < BUFFER_BYTES) begin
            v[8*k +: 8] = shadow_store[idx + k];
         end
      end
      return v;
   endfunction

   function automatic void fletcher_step(logic [7:0] b);
      sum_lo = (sum_lo + b) % 255;
      sum_hi = (sum_hi + sum_lo) % 255;
   endfunction

   function automatic rx_result_t receiver_step(cmd_type cmd, logic [7:0] b);
      rx_result_t  r;
      logic [15:0] hdr_len;
      logic [15:0] hdr_type;
      int unsigned width;
      r = '0;
      if (cmd == CMD_RECEIVE) begin
         if (rx_phase == PHASE_HUNT) begin
            if (b == SYNC_SECOND && last_rx == SYNC_FIRST) begin
               fill_pos = 2;
               last_rx = 8'h00;
               rx_phase = PHASE_HEADER;
               sum_lo = 0;
               sum_hi = 0;
               fletcher_step(SYNC_FIRST);
               fletcher_step(SYNC_SECOND);
            end else begin
               last_rx = b;
            end
         end else begin
            if (fill_pos < BUFFER_BYTES) begin
               shadow_store[fill_pos] = b;
            end
            fill_pos++;
            fletcher_step(b);
            hdr_len = 16'(gather_le(8, 2));
            hdr_type = 16'(gather_le(6, 2));
            if (rx_phase == PHASE_HEADER) begin
               if (fill_pos == HEADER_SIZE) begin
                  rx_phase = (hdr_len > MAX_LENGTH || (hdr_type & ~TYPE_ALLOWED) != 16'h0)
                             ? PHASE_HUNT : PHASE_DATA;
               end
            end else if (fill_pos == hdr_len + CHECK_BYTES + HEADER_SIZE) begin
               rx_phase = PHASE_HUNT;
               r.done = 1'b1;
               r.ftype = hdr_type;
               r.fid = gather_le(2, 4);
               r.flen = hdr_len[10:0];
               if (sum_lo == 0 && sum_hi == 0) begin
                  r.ok = 1'b1;
                  fill_pos -= CHECK_BYTES;
                  read_pos = HEADER_SIZE;
               end else begin
                  // bad frame: nothing left to read
                  read_pos = fill_pos;
               end
            end
         end
      end else begin
         width = (cmd == CMD_READ_BYTE) ? 1 : (cmd == CMD_READ_WORD) ? 2 : 4;
         if (read_pos + width <= fill_pos) begin
            r.rval = gather_le(read_pos, width);
            read_pos += width;
         end else if (width > 1) begin
            read_pos = fill_pos;
         end
      end
      r.left = (fill_pos > read_pos) ? 12'(fill_pos - read_pos) : 12'd0;
      r.at_end = (read_pos >= fill_pos);
      return r;
   endfunction

   function automatic void push_item(cmd_type cmd, logic [7:0] data);
      rx_items.push_back('{cmd, data, drain_next});
      drain_next = 1'b0;
      stim_count++;
   endfunction

   function automatic void push_reads(int unsigned count);
      for (int i = 0; i < count; i++) begin
         push_item(cmd_type'($urandom_range(3, 1)), 8'($urandom()));
      end
   endfunction

   // header only when the receiver is going to drop it; cut trims the tail for broken frames
   function automatic void push_frame(logic [31:0] id, logic [15:0] ftype, int unsigned len,
                                      bit corrupt, int unsigned read_pct, int unsigned cut);
      logic [7:0]  frame_bytes[$];
      logic [15:0] len16;
      int unsigned lo;
      int unsigned hi;
      int unsigned pos;
      len16 = len[15:0];
      frame_bytes = '{SYNC_FIRST, SYNC_SECOND, id[7:0], id[15:8], id[23:16], id[31:24],
                      ftype[7:0], ftype[15:8], len16[7:0], len16[15:8]};
      if (len <= MAX_LENGTH && (ftype & ~TYPE_ALLOWED) == 16'h0) begin
         for (int i = 0; i < len; i++) begin
            frame_bytes.push_back(($urandom_range(7) == 0)
               ? (($urandom_range(1) != 0) ? SYNC_FIRST : SYNC_SECOND) : 8'($urandom()));
         end
         lo = 0;
         hi = 0;
         foreach (frame_bytes[i]) begin
            lo = (lo + frame_bytes[i]) % 255;
            hi = (hi + lo) % 255;
         end
         frame_bytes.push_back(8'((510 - lo - hi) % 255));
         frame_bytes.push_back(8'(hi));
         // 0xff folds like zero, so it is an equally valid check byte
         for (int k = 0; k < 2; k++) begin
            pos = frame_bytes.size() - 1 - k;
            if (frame_bytes[pos] == 8'h00 && $urandom_range(1) != 0) begin
               frame_bytes[pos] = 8'hFF;
            end
         end
         if (corrupt) begin
            pos = $urandom_range(frame_bytes.size() - 1, HEADER_SIZE);
            frame_bytes[pos] ^= 8'($urandom_range(255, 1));
         end
         repeat (cut) void'(frame_bytes.pop_back());
      end
      foreach (frame_bytes[i]) begin
         if ($urandom_range(99) < read_pct) begin
            push_reads(1);
         end
         push_item(CMD_RECEIVE, frame_bytes[i]);
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // sender: bursts of items separated by random gaps
   always @(negedge clock) begin
      rx_item_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rx_items.size() == 0 ||
                      (rx_items[0].drain_first && awaited_results.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            nxt = rx_items.pop_front();
            req_valid <= 1'b1;
            req_command <= nxt.cmd;
            req_rx_byte <= nxt.data;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(16, 1);
               gap_left = ($urandom_range(1) == 0) ? 0 : $urandom_range(6, 1);
            end
         end
      end
   end

   // receiver: stall behavior switches among always ready, random, patterned and sparse modes
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(3));
            mode_left = $urandom_range(96, 16);
         end else begin
            mode_left--;
         end
         pattern_idx++;
         case (ready_mode)
            READY_ALWAYS: begin
               rsp_ready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_ready <= ($urandom_range(3) != 0);
            end
            READY_PATTERN: begin
               rsp_ready <= STALL_PATTERN[pattern_idx];
            end
            default: begin
               rsp_ready <= ($urandom_range(3) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      item_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         awaited_results.push_back(receiver_step(req_command, req_rx_byte));
      end
   end

   always @(posedge clock) begin
      rx_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("response with no item outstanding");
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("frame_done", 32'(want.done), 32'(rsp_frame_done));
            check_field("checksum_ok", 32'(want.ok), 32'(rsp_checksum_ok));
            check_field("frame_type", 32'(want.ftype), 32'(rsp_frame_type));
            check_field("frame_id", want.fid, rsp_frame_id);
            check_field("frame_length", 32'(want.flen), 32'(rsp_frame_length));
            check_field("read_value", want.rval, rsp_read_value);
            check_field("bytes_left", 32'(want.left), 32'(rsp_bytes_left));
            check_field("at_end", 32'(want.at_end), 32'(rsp_at_end));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int          pick;
      int unsigned len;
      int unsigned cut;
      foreach (shadow_store[i]) begin
         shadow_store[i] = 8'h00;
      end
      shadow_store[0] = SYNC_FIRST;
      shadow_store[1] = SYNC_SECOND;

      // reads on an empty buffer
      push_item(CMD_READ_BYTE, 8'hFF);
      push_item(CMD_READ_WORD, 8'h00);
      push_item(CMD_READ_DWORD, 8'hA5);
      // doubled sync lead-in, then a length one past the buffer
      push_item(CMD_RECEIVE, SYNC_FIRST);
      push_frame(32'hFFFF_FFFF, 16'h0000, MAX_LENGTH + 1, 1'b0, 0, 0);
      // empty payload with every allowed type bit
      push_frame(32'h0000_0000, TYPE_ALLOWED, 0, 1'b0, 0, 0);
      push_item(CMD_READ_DWORD, 8'h00);

      drain_next = 1'b1;
      while (stim_count < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(300, 41) : $urandom_range(40);
            cut = ($urandom_range(11) == 0) ? $urandom_range(len + 2, 1) : 0;
            if ($urandom_range(7) == 0) begin
               drain_next = 1'b1;
            end
            push_frame($urandom(), 16'($urandom()) & TYPE_ALLOWED, len,
                       $urandom_range(4) == 0,
                       ($urandom_range(1) != 0) ? 0 : $urandom_range(30, 5), cut);
            push_reads($urandom_range(len / 2 + 4));
         end else if (pick < 65) begin
            if ($urandom_range(1) != 0) begin
               push_frame($urandom(), 16'($urandom()) | (16'h0400 << $urandom_range(4)),
                          $urandom_range(40), 1'b0, 10, 0);
            end else begin
               push_frame($urandom(), 16'($urandom()) & TYPE_ALLOWED,
                          $urandom_range(65535, MAX_LENGTH + 1), 1'b0, 10, 0);
            end
         end else if (pick < 75) begin
            // line noise between frames
            repeat ($urandom_range(8, 1)) begin
               push_item(CMD_RECEIVE,
                         ($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom()));
            end
         end else begin
            push_reads($urandom_range(12, 1));
         end
      end

      wait (!reset);
      do begin
         @(posedge clock);
      end while (rx_items.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
